>>> rtl/vrrp_v3_router_election_fsm_macros.svh
// ----------------------------------------------------------------------------
// vrrp election engine assertion macros
// shared property shorthands, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef VRRP_V3_ROUTER_ELECTION_FSM_MACROS_SVH
`define VRRP_V3_ROUTER_ELECTION_FSM_MACROS_SVH

// same-cycle implication
`define VRRP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vrrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrp_pkg
// types, codes and widths shared by the vrrp election engine
// ----------------------------------------------------------------------------
package vrrp_pkg;

  localparam int unsigned USEC_PER_CSEC = 10000;

  localparam int unsigned CSEC_W  = 12;
  localparam int unsigned IV_W    = 26;
  localparam int unsigned CNT_W   = 28;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned SPAN_W  = PRIO_W + 1;
  localparam int unsigned USEC_W  = $clog2(USEC_PER_CSEC + 1);
  localparam int unsigned MUL_B_W = (USEC_W > SPAN_W) ? USEC_W : SPAN_W;
  localparam int unsigned MUL_P_W = IV_W + MUL_B_W;

  localparam logic [SPAN_W-1:0]  PRIO_SPAN  = SPAN_W'(256);
  localparam logic [MUL_B_W-1:0] DOWN_MULT  = MUL_B_W'(3);
  localparam logic [MUL_B_W-1:0] USEC_MULT  = MUL_B_W'(USEC_PER_CSEC);
  localparam logic [PRIO_W-1:0]  PRIO_OWNER = 8'hff;
  localparam logic [7:0]         TTL_REQ    = 8'hff;
  localparam logic [3:0]         VER_REQ    = 4'h3;

  // election states
  localparam logic [1:0] ST_INIT    = 2'd0;
  localparam logic [1:0] ST_BACKUP  = 2'd1;
  localparam logic [1:0] ST_MASTER  = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ADV  = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // mac actions
  localparam logic [1:0] MAC_NONE    = 2'd0;
  localparam logic [1:0] MAC_TAKE    = 2'd1;
  localparam logic [1:0] MAC_RESTORE = 2'd2;

  // advertisement status
  localparam logic [1:0] ADV_NONE    = 2'd0;
  localparam logic [1:0] ADV_ACTED   = 2'd1;
  localparam logic [1:0] ADV_REJECT  = 2'd2;
  localparam logic [1:0] ADV_DISCARD = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PRIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_IVL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 3'd4;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [7:0]        router_id;
    logic [PRIO_W-1:0] local_priority;
    logic              preempt_enable;
    logic [CSEC_W-1:0] adver_interval_csec;
    logic [31:0]       own_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        adv_ttl;
    logic [3:0]        adv_version;
    logic [7:0]        adv_router_id;
    logic [PRIO_W-1:0] adv_priority;
    logic [CSEC_W-1:0] adv_interval_csec;
    logic [31:0]       adv_source_address;
    logic              adv_checks_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]        router_state;
    logic              send_advert;
    logic [PRIO_W-1:0] advert_priority;
    logic              send_garp;
    logic [1:0]        mac_action;
    logic [1:0]        advert_status;
  } res_t;

endpackage

>>> rtl/vrrp_muladd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrp_muladd
// shared multiply-add unit with registered product, p = a * b + c
// ----------------------------------------------------------------------------
module vrrp_muladd
  import vrrp_pkg::*;
(
  input  logic               clk_i,
  input  logic [IV_W-1:0]    a_i,
  input  logic [MUL_B_W-1:0] b_i,
  input  logic [IV_W-1:0]    c_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_d, p_q;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i) + MUL_P_W'(c_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> rtl/vrrp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrp_core
// election state, timers and the sequencer that drives the shared multiplier
// ----------------------------------------------------------------------------
module vrrp_core
  import vrrp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  start_i,
  input  item_t item_i,
  input  logic  slot_free_i,
  output logic  idle_o,
  output logic  done_o,
  output res_t  res_o
);

`include "vrrp_v3_router_election_fsm_macros.svh"

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_IV   = 3'd1;
  localparam logic [2:0] SQ_SKEW = 3'd2;
  localparam logic [2:0] SQ_DOWN = 3'd3;
  localparam logic [2:0] SQ_OWN  = 3'd4;
  localparam logic [2:0] SQ_FIN  = 3'd5;

  logic [2:0]       seq_d, seq_q;
  logic [1:0]       fsm_d, fsm_q;
  logic [CNT_W-1:0] adv_cnt_d, adv_cnt_q;
  logic [CNT_W-1:0] md_cnt_d, md_cnt_q;
  logic [IV_W-1:0]  skew_d, skew_q;
  item_t            item_q;
  logic [IV_W-1:0]  iv_q, skew_new_q;
  logic [CNT_W-1:0] down_new_q;

  logic [IV_W-1:0]    mul_a, mul_c;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [SPAN_W-1:0]  skew_mult;
  logic [CSEC_W-1:0]  learn_csec;
  logic               learn_needed;

  logic [CNT_W-1:0] own_usec, adv_dec, md_dec;
  logic             adv_valid, higher;
  logic [PRIO_W-1:0] lp;
  res_t             res;

  vrrp_muladd u_muladd (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .c_i   (mul_c),
    .p_o   (mul_p)
  );

  assign lp         = cfg_i.local_priority;
  assign skew_mult  = PRIO_SPAN - {1'b0, lp};
  assign learn_csec = (fsm_q == ST_INIT) ? cfg_i.adver_interval_csec
                                         : item_q.adv_interval_csec;

  // learning runs on a tick in init and on any advertisement in init, master or backup
  assign learn_needed = ((item_i.req_type == REQ_TICK) && (fsm_q == ST_INIT)) ||
                        ((item_i.req_type == REQ_ADV) && (fsm_q != ST_STOPPED));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    unique case (seq_q)
      SQ_IV: begin
        mul_a = IV_W'(learn_csec);
        mul_b = USEC_MULT;
      end
      SQ_SKEW: begin
        mul_a = mul_p[IV_W-1:0];
        mul_b = MUL_B_W'(skew_mult);
      end
      SQ_DOWN: begin
        mul_a = iv_q;
        mul_b = DOWN_MULT;
        mul_c = mul_p[IV_W+7:8];
      end
      // own interval stays on the unit while the commit waits for the slot
      SQ_OWN, SQ_FIN: begin
        mul_a = IV_W'(cfg_i.adver_interval_csec);
        mul_b = USEC_MULT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE: if (start_i) seq_d = learn_needed ? SQ_IV : SQ_OWN;
      SQ_IV:   seq_d = SQ_SKEW;
      SQ_SKEW: seq_d = SQ_DOWN;
      SQ_DOWN: seq_d = SQ_OWN;
      SQ_OWN:  seq_d = SQ_FIN;
      SQ_FIN:  if (slot_free_i) seq_d = SQ_IDLE;
      default: seq_d = SQ_IDLE;
    endcase
  end

  // in the final step the multiplier holds the own interval in usec
  assign own_usec  = CNT_W'(mul_p[IV_W-1:0]);
  assign adv_dec   = (adv_cnt_q != '0) ? adv_cnt_q - CNT_W'(1) : '0;
  assign md_dec    = (md_cnt_q != '0) ? md_cnt_q - CNT_W'(1) : '0;
  assign adv_valid = (item_q.adv_ttl == TTL_REQ) && (item_q.adv_version == VER_REQ) &&
                     (item_q.adv_router_id == cfg_i.router_id) && item_q.adv_checks_ok;
  assign higher    = (item_q.adv_priority > lp) ||
                     ((item_q.adv_priority == lp) &&
                      (item_q.adv_source_address > cfg_i.own_address));

  always_comb begin
    fsm_d     = fsm_q;
    adv_cnt_d = adv_cnt_q;
    md_cnt_d  = md_cnt_q;
    skew_d    = skew_q;
    res       = '0;
    if (item_q.req_type != REQ_NONE) begin
      unique case (fsm_q)
        ST_INIT: begin
          if (item_q.req_type == REQ_STOP) begin
            fsm_d = ST_STOPPED;
          end else begin
            skew_d = skew_new_q;
            if (lp == PRIO_OWNER) begin
              res.send_advert     = 1'b1;
              res.advert_priority = lp;
              res.send_garp       = 1'b1;
              res.mac_action      = MAC_TAKE;
              adv_cnt_d           = own_usec;
              md_cnt_d            = '0;
              fsm_d               = ST_MASTER;
            end else begin
              adv_cnt_d = '0;
              md_cnt_d  = down_new_q;
              fsm_d     = ST_BACKUP;
            end
            if (item_q.req_type == REQ_ADV) res.advert_status = ADV_DISCARD;
          end
        end
        ST_MASTER: begin
          priority if (item_q.req_type == REQ_STOP) begin
            res.mac_action  = MAC_RESTORE;
            res.send_advert = 1'b1;
            adv_cnt_d       = '0;
            md_cnt_d        = '0;
            fsm_d           = ST_STOPPED;
          end else if (item_q.req_type == REQ_TICK) begin
            if (adv_dec == '0) begin
              res.send_advert     = 1'b1;
              res.advert_priority = lp;
              adv_cnt_d           = own_usec;
            end else begin
              adv_cnt_d = adv_dec;
            end
          end else if (!adv_valid) begin
            res.advert_status = ADV_REJECT;
          end else if (item_q.adv_priority == '0) begin
            res.send_advert     = 1'b1;
            res.advert_priority = lp;
            adv_cnt_d           = own_usec;
            res.advert_status   = ADV_ACTED;
          end else if (higher) begin
            res.mac_action    = MAC_RESTORE;
            skew_d            = skew_new_q;
            adv_cnt_d         = '0;
            md_cnt_d          = down_new_q;
            fsm_d             = ST_BACKUP;
            res.advert_status = ADV_ACTED;
          end else begin
            res.advert_status = ADV_DISCARD;
          end
        end
        ST_BACKUP: begin
          priority if (item_q.req_type == REQ_STOP) begin
            adv_cnt_d = '0;
            md_cnt_d  = '0;
            fsm_d     = ST_STOPPED;
          end else if (item_q.req_type == REQ_TICK) begin
            if (md_dec == '0) begin
              res.send_advert     = 1'b1;
              res.advert_priority = lp;
              res.send_garp       = 1'b1;
              res.mac_action      = MAC_TAKE;
              adv_cnt_d           = own_usec;
              md_cnt_d            = '0;
              fsm_d               = ST_MASTER;
            end else begin
              md_cnt_d = md_dec;
            end
          end else if (!adv_valid) begin
            res.advert_status = ADV_REJECT;
          end else if (item_q.adv_priority == '0) begin
            md_cnt_d          = CNT_W'(skew_q);
            res.advert_status = ADV_ACTED;
          end else if (!cfg_i.preempt_enable || (item_q.adv_priority >= lp)) begin
            skew_d            = skew_new_q;
            md_cnt_d          = down_new_q;
            res.advert_status = ADV_ACTED;
          end else begin
            res.advert_status = ADV_DISCARD;
          end
        end
        ST_STOPPED: begin
          if (item_q.req_type == REQ_ADV) res.advert_status = ADV_DISCARD;
        end
        default: begin
        end
      endcase
    end
    res.router_state = fsm_d;
  end

  assign done_o = (seq_q == SQ_FIN) && slot_free_i;
  assign idle_o = (seq_q == SQ_IDLE);
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SQ_IDLE;
      fsm_q     <= ST_INIT;
      adv_cnt_q <= '0;
      md_cnt_q  <= '0;
      skew_q    <= '0;
    end else begin
      seq_q <= seq_d;
      if (done_o) begin
        fsm_q     <= fsm_d;
        adv_cnt_q <= adv_cnt_d;
        md_cnt_q  <= md_cnt_d;
        skew_q    <= skew_d;
      end
    end
  end

  // intermediate results of the multiply sequence
  always_ff @(posedge clk_i) begin
    if (start_i) item_q <= item_i;
    if (seq_q == SQ_SKEW) iv_q <= mul_p[IV_W-1:0];
    if (seq_q == SQ_DOWN) skew_new_q <= mul_p[IV_W+7:8];
    if (seq_q == SQ_OWN) down_new_q <= mul_p[CNT_W-1:0];
  end

  `VRRP_ASSERT_IMPL(a_start_when_idle, start_i, seq_q == SQ_IDLE, "item taken while busy")
  `VRRP_ASSERT_NEXT(a_start_leaves_idle, start_i, seq_q != SQ_IDLE, "sequencer did not start")
  `VRRP_ASSERT_NEXT(a_stopped_sticks, fsm_q == ST_STOPPED, fsm_q == ST_STOPPED,
                    "left stopped state")
  `VRRP_ASSERT_IMPL(a_master_no_down_timer, fsm_q == ST_MASTER, md_cnt_q == '0,
                    "master-down timer running in master")
  `VRRP_ASSERT_IMPL(a_backup_no_adv_timer, fsm_q == ST_BACKUP, adv_cnt_q == '0,
                    "advert timer running in backup")

endmodule

>>> rtl/vrrp_v3_router_election_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrp_v3_router_election_fsm
// vrrpv3 master/backup election engine with config registers and result register
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid_i/tready_o      tdata advert summary, tuser kind
//  m_axis    out        m_axis_tvalid_o/tready_i      tdata result item
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
//  items that learn no interval (shutdowns, ignored kinds, ticks outside init,
//  adverts while stopped) need one multiply of the own interval on the shared
//  multiply-add unit, then the commit step. items that learn an interval run
//  interval, skew, down interval and own interval through the same unit one after another.
//  s_axis_tready_o is high only while the sequencer is idle; a held result
//  does not block the next item, only its commit step waits for the slot.
//  reset puts the engine in init with cleared timers and default registers.
// ----------------------------------------------------------------------------
module vrrp_v3_router_election_fsm
  import vrrp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // adv_ttl, adv_version, adv_router_id, adv_priority, adv_interval_csec,
  // adv_source_address, adv_checks_ok, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // router_state, send_advert, advert_priority, send_garp, mac_action,
  // advert_status
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  cfg_t  cfg_d, cfg_q;
  item_t item;
  res_t  res;
  logic  start, idle, done, slot_free;
  logic  out_valid_d, out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign item.req_type           = s_axis_tuser_i;
  assign item.adv_ttl            = s_axis_tdata_i[7:0];
  assign item.adv_version        = s_axis_tdata_i[11:8];
  assign item.adv_router_id      = s_axis_tdata_i[19:12];
  assign item.adv_priority       = s_axis_tdata_i[27:20];
  assign item.adv_interval_csec  = s_axis_tdata_i[39:28];
  assign item.adv_source_address = s_axis_tdata_i[71:40];
  assign item.adv_checks_ok      = s_axis_tdata_i[72];

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROUTER_ID:  cfg_d.router_id           = cfg_data_i[7:0];
        CFG_LOCAL_PRIO: cfg_d.local_priority      = cfg_data_i[PRIO_W-1:0];
        CFG_PREEMPT:    cfg_d.preempt_enable      = cfg_data_i[0];
        CFG_ADV_IVL:    cfg_d.adver_interval_csec = cfg_data_i[CSEC_W-1:0];
        CFG_OWN_ADDR:   cfg_d.own_address         = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vrrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .item_i      (item),
    .slot_free_i (slot_free),
    .idle_o      (idle),
    .done_o      (done),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.router_id           <= 8'd1;
      cfg_q.local_priority      <= 8'd100;
      cfg_q.preempt_enable      <= 1'b1;
      cfg_q.adver_interval_csec <= 12'd100;
      cfg_q.own_address         <= '0;
      out_valid_q               <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= {res.advert_status, res.mac_action, res.send_garp,
                     res.advert_priority, res.send_advert, res.router_state};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the vrrp election engine: a directed table first
// (start-up, timeouts, rejects, ties, preemption), then random phases with
// register changes between them, then shutdown and the stopped state. every
// accepted item is run through a local copy of the election logic and each
// result item is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import vrrp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned QUIET_PHASES  = 2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = REQ_NONE;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ROUTER_ID;
  logic [31:0]           cfg_data_i = '0;

  vrrp_v3_router_election_fsm i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // local copy of registers and election state
  cfg_t        vrrp_regs = '{router_id: 8'd1, local_priority: 8'd100, preempt_enable: 1'b1,
                             adver_interval_csec: 12'd100, own_address: 32'd0};
  logic [1:0]  el_state = ST_INIT;
  logic [27:0] adv_cnt = '0;
  logic [27:0] down_cnt = '0;
  logic [25:0] mstr_ivl = '0;
  logic [25:0] skew_us = '0;
  logic [27:0] down_us = '0;

  res_t        due_results[$];
  bit          idle_on = 1'b1;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          n_ticks = 0, n_adverts = 0, n_ignored = 0, n_stops = 0;
  int          n_master_entries = 0, n_periodic = 0;
  int          n_acted = 0, n_rejected = 0, n_discarded = 0;

  function automatic logic [25:0] csec_usec(logic [CSEC_W-1:0] csec);
    logic [63:0] prod;
    prod = 64'(csec) * 64'(USEC_PER_CSEC);
    return prod[25:0];
  endfunction

  function automatic void learn_ivl(logic [25:0] ivl);
    logic [63:0] sk;
    logic [63:0] dn;
    sk = (64'd256 - 64'(vrrp_regs.local_priority)) * 64'(ivl) / 64'd256;
    mstr_ivl = ivl;
    skew_us = sk[25:0];
    dn = 64'd3 * 64'(ivl) + 64'(skew_us);
    down_us = dn[27:0];
  endfunction

  // saturating countdown, fires when it lands on zero
  function automatic logic count_down(inout logic [27:0] cnt);
    if (cnt != '0) cnt = cnt - 28'd1;
    return cnt == '0;
  endfunction

  function automatic void enter_master(inout res_t r);
    r.send_advert = 1'b1;
    r.advert_priority = vrrp_regs.local_priority;
    r.send_garp = 1'b1;
    r.mac_action = MAC_TAKE;
    adv_cnt = 28'(csec_usec(vrrp_regs.adver_interval_csec));
    down_cnt = '0;
    el_state = ST_MASTER;
    n_master_entries++;
  endfunction

  function automatic void enter_backup();
    adv_cnt = '0;
    down_cnt = down_us;
    el_state = ST_BACKUP;
  endfunction

  function automatic res_t elect_step(item_t it);
    res_t r;
    logic adv_ok;
    logic [7:0] lp;
    r = '0;
    lp = vrrp_regs.local_priority;
    adv_ok = it.adv_ttl == TTL_REQ && it.adv_version == VER_REQ &&
             it.adv_router_id == vrrp_regs.router_id && it.adv_checks_ok;
    if (it.req_type != REQ_NONE) begin
      case (el_state)
        ST_INIT: begin
          if (it.req_type == REQ_STOP) begin
            el_state = ST_STOPPED;
          end else begin
            learn_ivl(csec_usec(vrrp_regs.adver_interval_csec));
            if (lp == PRIO_OWNER) enter_master(r);
            else enter_backup();
            if (it.req_type == REQ_ADV) r.advert_status = ADV_DISCARD;
          end
        end
        ST_MASTER: begin
          if (it.req_type == REQ_STOP) begin
            r.mac_action = MAC_RESTORE;
            r.send_advert = 1'b1;
            adv_cnt = '0;
            down_cnt = '0;
            el_state = ST_STOPPED;
          end else if (it.req_type == REQ_TICK) begin
            if (count_down(adv_cnt)) begin
              r.send_advert = 1'b1;
              r.advert_priority = lp;
              adv_cnt = 28'(csec_usec(vrrp_regs.adver_interval_csec));
              n_periodic++;
            end
          end else if (!adv_ok) begin
            r.advert_status = ADV_REJECT;
          end else if (it.adv_priority == '0) begin
            // other master is leaving: answer at once
            r.send_advert = 1'b1;
            r.advert_priority = lp;
            adv_cnt = 28'(csec_usec(vrrp_regs.adver_interval_csec));
            r.advert_status = ADV_ACTED;
          end else if (it.adv_priority > lp ||
                       (it.adv_priority == lp && it.adv_source_address > vrrp_regs.own_address)) begin
            r.mac_action = MAC_RESTORE;
            learn_ivl(csec_usec(it.adv_interval_csec));
            enter_backup();
            r.advert_status = ADV_ACTED;
          end else begin
            r.advert_status = ADV_DISCARD;
          end
        end
        ST_BACKUP: begin
          if (it.req_type == REQ_STOP) begin
            adv_cnt = '0;
            down_cnt = '0;
            el_state = ST_STOPPED;
          end else if (it.req_type == REQ_TICK) begin
            if (count_down(down_cnt)) enter_master(r);
          end else if (!adv_ok) begin
            r.advert_status = ADV_REJECT;
          end else if (it.adv_priority == '0) begin
            down_cnt = 28'(skew_us);
            r.advert_status = ADV_ACTED;
          end else if (!vrrp_regs.preempt_enable || it.adv_priority >= lp) begin
            learn_ivl(csec_usec(it.adv_interval_csec));
            down_cnt = down_us;
            r.advert_status = ADV_ACTED;
          end else begin
            r.advert_status = ADV_DISCARD;
          end
        end
        default: begin
          if (it.req_type == REQ_ADV) r.advert_status = ADV_DISCARD;
        end
      endcase
    end
    r.router_state = el_state;
    case (r.advert_status)
      ADV_ACTED:   n_acted++;
      ADV_REJECT:  n_rejected++;
      ADV_DISCARD: n_discarded++;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] d);
    res_t got;
    res_t want;
    got.router_state    = d[1:0];
    got.send_advert     = d[2];
    got.advert_priority = d[10:3];
    got.send_garp       = d[11];
    got.mac_action      = d[13:12];
    got.advert_status   = d[15:14];
    results_seen++;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing outstanding, data %h",
                                results_seen, d));
    end else begin
      want = due_results.pop_front();
      if (got.router_state != want.router_state)
        report_mismatch($sformatf("result %0d router_state %0d, want %0d", results_seen,
                                  got.router_state, want.router_state));
      if (got.send_advert != want.send_advert)
        report_mismatch($sformatf("result %0d send_advert %0d, want %0d", results_seen,
                                  got.send_advert, want.send_advert));
      if (got.advert_priority != want.advert_priority)
        report_mismatch($sformatf("result %0d advert_priority %0d, want %0d", results_seen,
                                  got.advert_priority, want.advert_priority));
      if (got.send_garp != want.send_garp)
        report_mismatch($sformatf("result %0d send_garp %0d, want %0d", results_seen,
                                  got.send_garp, want.send_garp));
      if (got.mac_action != want.mac_action)
        report_mismatch($sformatf("result %0d mac_action %0d, want %0d", results_seen,
                                  got.mac_action, want.mac_action));
      if (got.advert_status != want.advert_status)
        report_mismatch($sformatf("result %0d advert_status %0d, want %0d", results_seen,
                                  got.advert_status, want.advert_status));
    end
  endtask

  // result side: check, then decide the next ready with random stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(item_t it, bit typed, res_t want);
    res_t pred;
    int gap;
    cfg_valid_i <= 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, it.adv_checks_ok, it.adv_source_address, it.adv_interval_csec,
                        it.adv_priority, it.adv_router_id, it.adv_version, it.adv_ttl};
    s_axis_tuser_i  <= it.req_type;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    case (it.req_type)
      REQ_TICK: n_ticks++;
      REQ_ADV:  n_adverts++;
      REQ_STOP: n_stops++;
      default:  n_ignored++;
    endcase
    pred = elect_step(it);
    due_results.push_back(typed ? want : pred);
  endtask

  // hold off new items until every result is back and the engine has settled
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ROUTER_ID:  vrrp_regs.router_id = val[7:0];
      CFG_LOCAL_PRIO: vrrp_regs.local_priority = val[7:0];
      CFG_PREEMPT:    vrrp_regs.preempt_enable = val[0];
      CFG_ADV_IVL:    vrrp_regs.adver_interval_csec = val[11:0];
      CFG_OWN_ADDR:   vrrp_regs.own_address = val;
      default: ;
    endcase
  endtask

  task automatic retune_regs(bit all_regs);
    logic [31:0] val;
    if (all_regs || $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: val = 32'd1;
        1: val = 32'd255;
        default: val = $urandom_range(1, 255);
      endcase
      write_reg(CFG_ROUTER_ID, val);
    end
    if (all_regs || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 4))
        0: val = 32'd1;
        1: val = 32'd255;
        2: val = $urandom_range(250, 254);
        default: val = $urandom_range(1, 254);
      endcase
      write_reg(CFG_LOCAL_PRIO, val);
    end
    if (all_regs || $urandom_range(0, 2) == 0) write_reg(CFG_PREEMPT, $urandom_range(0, 1));
    if (all_regs || $urandom_range(0, 1) == 0) begin
      // zero interval keeps the master advertising on every tick
      case ($urandom_range(0, 5))
        0, 1: val = 32'd0;
        2: val = 32'd1;
        3: val = 32'd4095;
        4: val = $urandom_range(2, 20);
        default: val = $urandom_range(1, 4095);
      endcase
      write_reg(CFG_ADV_IVL, val);
    end
    if (all_regs || $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: val = 32'd0;
        1: val = 32'hffff_ffff;
        default: val = $urandom;
      endcase
      write_reg(CFG_OWN_ADDR, val);
    end
  endtask

  function automatic item_t mk_item(logic [1:0] req, logic [7:0] ttl, logic [3:0] ver,
                                    logic [7:0] vrid, logic [7:0] prio, logic [11:0] ivl,
                                    logic [31:0] src, logic ok);
    item_t it;
    it.req_type = req;
    it.adv_ttl = ttl;
    it.adv_version = ver;
    it.adv_router_id = vrid;
    it.adv_priority = prio;
    it.adv_interval_csec = ivl;
    it.adv_source_address = src;
    it.adv_checks_ok = ok;
    return it;
  endfunction

  // ticks, ignored kinds and adverts, mostly well-formed and near the decision edges
  function automatic item_t rand_item();
    item_t it;
    logic [7:0] lp;
    logic [3:0] ver;
    int pick;
    lp = vrrp_regs.local_priority;
    it = mk_item(REQ_ADV, TTL_REQ, VER_REQ, vrrp_regs.router_id, 8'($urandom_range(0, 255)),
                 12'($urandom_range(0, 4095)), $urandom, 1'b1);
    case ($urandom_range(0, 9))
      0, 1: it.adv_priority = 8'd0;
      2: it.adv_priority = lp;
      3: it.adv_priority = (lp == 8'd255) ? lp : lp + 8'd1;
      4: it.adv_priority = lp - 8'd1;
      5: it.adv_priority = 8'd255;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: it.adv_interval_csec = 12'd0;
      4: it.adv_interval_csec = 12'd1;
      5: it.adv_interval_csec = 12'd4095;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: it.adv_source_address = vrrp_regs.own_address;
      1: it.adv_source_address = vrrp_regs.own_address + 32'd1;
      2: it.adv_source_address = vrrp_regs.own_address - 32'd1;
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.req_type = REQ_TICK;
    end else if (pick < 80) begin
      it.req_type = REQ_ADV;
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: it.adv_ttl = 8'($urandom_range(0, 254));
        1: begin
          ver = 4'($urandom_range(0, 14));
          it.adv_version = (ver >= VER_REQ) ? ver + 4'd1 : ver;
        end
        2: it.adv_router_id = vrrp_regs.router_id + 8'($urandom_range(1, 255));
        default: it.adv_checks_ok = 1'b0;
      endcase
    end else if (pick < 97) begin
      it = mk_item(REQ_ADV, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   12'($urandom_range(0, 4095)), $urandom, 1'($urandom_range(0, 1)));
    end else begin
      it.req_type = REQ_NONE;
    end
    return it;
  endfunction

  function automatic res_t mk_res(logic [1:0] st, logic send, logic [7:0] prio, logic garp,
                                  logic [1:0] mac, logic [1:0] status);
    res_t r;
    r.router_state = st;
    r.send_advert = send;
    r.advert_priority = prio;
    r.send_garp = garp;
    r.mac_action = mac;
    r.advert_status = status;
    return r;
  endfunction

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    item_t                it;
    bit                   typed;
    res_t                 want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    plan_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, it: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void row_item(item_t it, bit typed, res_t want);
    plan_row_t row;
    row = '{is_reg: 1'b0, reg_idx: CFG_ROUTER_ID, reg_val: '0, it: it, typed: typed,
            want: want};
    plan.push_back(row);
  endfunction

  initial begin
    item_t it;
    bit prev_reg;
    int counted;
    res_t none;
    none = '0;

    // directed table; the first tick leaves init as backup or, as owner, master
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 0, none);
    row_reg(CFG_LOCAL_PRIO, 32'd200);
    row_reg(CFG_ROUTER_ID, 32'd255);
    row_reg(CFG_ADV_IVL, 32'd0);
    row_reg(CFG_OWN_ADDR, 32'd0);
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd255, 12'd0, 32'hffff_ffff, 1'b1),
             0, none);
    // zero master-down: next tick takes over
    row_item(mk_item(REQ_TICK, 8'hff, 4'hf, 8'hff, 8'hff, 12'hfff, 32'hffff_ffff, 1'b1), 1,
             mk_res(ST_MASTER, 1'b1, 8'd200, 1'b1, MAC_TAKE, ADV_NONE));
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_MASTER, 1'b1, 8'd200, 1'b0, MAC_NONE, ADV_NONE));
    row_item(mk_item(REQ_ADV, 8'd254, VER_REQ, 8'd255, 8'd255, 12'd0, 32'd5, 1'b1), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_REJECT));
    row_item(mk_item(REQ_ADV, TTL_REQ, 4'd2, 8'd255, 8'd255, 12'd0, 32'd5, 1'b1), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_REJECT));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd1, 8'd255, 12'd0, 32'd5, 1'b1), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_REJECT));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd255, 12'd0, 32'd5, 1'b0), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_REJECT));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd0, 12'd7, 32'd5, 1'b1), 1,
             mk_res(ST_MASTER, 1'b1, 8'd200, 1'b0, MAC_NONE, ADV_ACTED));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd199, 12'd0, 32'hffff_ffff, 1'b1), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_DISCARD));
    // equal priority, equal address: we stay
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd200, 12'd0, 32'd0, 1'b1), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_DISCARD));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd200, 12'd4095, 32'd1, 1'b1), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_RESTORE, ADV_ACTED));
    row_item(mk_item(REQ_NONE, 8'hff, 4'hf, 8'hff, 8'hff, 12'hfff, 32'hffff_ffff, 1'b1), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd0, 12'd3, 32'd9, 1'b1), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_ACTED));
    row_reg(CFG_PREEMPT, 32'd0);
    // no preemption: a lower priority master is accepted
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd1, 12'd0, 32'd9, 1'b1), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_ACTED));
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_MASTER, 1'b1, 8'd200, 1'b1, MAC_TAKE, ADV_NONE));
    row_item(mk_item(REQ_NONE, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    row_reg(CFG_PREEMPT, 32'd1);
    row_reg(CFG_ADV_IVL, 32'd4095);
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_MASTER, 1'b1, 8'd200, 1'b0, MAC_NONE, ADV_NONE));
    row_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
             mk_res(ST_MASTER, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    row_reg(CFG_LOCAL_PRIO, 32'd254);
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd255, 12'd1, 32'd0, 1'b1), 0, none);
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd253, 12'd0, 32'd0, 1'b1), 1,
             mk_res(ST_BACKUP, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_DISCARD));
    // short skew, so random ticks can run it out
    row_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, 8'd255, 8'd0, 12'd0, 32'd0, 1'b1), 0, none);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    if ($urandom_range(0, 1) == 1) write_reg(CFG_LOCAL_PRIO, {24'd0, PRIO_OWNER});

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].it, plan[i].typed, plan[i].want);
      end
      prev_reg = plan[i].is_reg;
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      retune_regs(phase == 0);
      idle_on = (phase < NUM_PHASES - QUIET_PHASES) ? ($urandom_range(0, 3) != 0) : 1'b0;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item();
        send_item(it, 1'b0, none);
        if (it.req_type != REQ_NONE) counted++;
      end
    end

    // wind down: sometimes force mastership first so shutdown restores the mac
    if (el_state == ST_BACKUP && $urandom_range(0, 1) == 1) begin
      send_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, vrrp_regs.router_id, 8'd255, 12'd0,
                        $urandom, 1'b1), 1'b0, none);
      send_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1'b0, none);
    end
    send_item(mk_item(REQ_STOP, 8'hff, 4'hf, 8'hff, 8'hff, 12'hfff, 32'hffff_ffff, 1'b1),
              1'b0, none);
    send_item(mk_item(REQ_TICK, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
              mk_res(ST_STOPPED, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    send_item(mk_item(REQ_ADV, TTL_REQ, VER_REQ, vrrp_regs.router_id, 8'd0, 12'd0, 32'd0, 1'b1),
              1, mk_res(ST_STOPPED, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_DISCARD));
    send_item(mk_item(REQ_NONE, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
              mk_res(ST_STOPPED, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    send_item(mk_item(REQ_STOP, 8'h00, 4'h0, 8'h00, 8'h00, 12'd0, 32'd0, 1'b0), 1,
              mk_res(ST_STOPPED, 1'b0, 8'd0, 1'b0, MAC_NONE, ADV_NONE));
    s_axis_tvalid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    $display("covered %0d items: %0d ticks, %0d adverts, %0d shutdowns, %0d ignored; %0d results",
             n_ticks + n_adverts + n_stops + n_ignored, n_ticks, n_adverts, n_stops, n_ignored,
             results_seen);
    $display("masters %0d, timed %0d, acted %0d, rejected %0d, discarded %0d, mismatches %0d",
             n_master_entries, n_periodic, n_acted, n_rejected, n_discarded, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
